// File: rtl/cmp_pkg.sv
// Shared constants, angle table and types for the complex magnitude and phase block.
package cmp_pkg;

  // Default parameter values for the top level.
  localparam int SAMPLE_WIDTH_DEF = 18;
  localparam int ITERATIONS_DEF   = 16;

  // Fraction bits added to the sample before the rotations.
  localparam int GUARD = 6;
  // Extra integer bits that absorb the growth of the rotations.
  localparam int HEADROOM = 3;

  // Result field widths.
  localparam int MAG_W   = 18;
  localparam int PHASE_W = 16;

  // Angle accumulator: 2^32 is a full turn.
  localparam int ANGLE_W = 32;
  localparam logic [ANGLE_W-1:0] ANGLE_PI   = 32'h8000_0000;
  localparam logic [ANGLE_W-1:0] ANGLE_HALF = 32'h0000_8000;

  // Gain correction, about 0.60723 in Q24.
  localparam int GAIN_W = 24;
  localparam logic [GAIN_W-1:0] GAIN_Q24 = 24'd10187623;

  // Largest magnitude that fits the result field.
  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  // Arctangent of 2^-i in angle units, one entry per micro-rotation.
  localparam int ATAN_LEN = 24;
  localparam logic [ANGLE_W-1:0] ATAN_TABLE [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Side flags that travel with each word down the pipeline.
  typedef struct packed {
    logic last;
    logic zero;
  } cmp_tag_t;

endpackage

// File: rtl/complex_magnitude_phase.sv
// Top level of the pipelined CORDIC magnitude and phase block.

// Takes one complex sample per word and returns its magnitude (same scale as the
// inputs, saturating at 2^18-1) and its phase in binary angle units, where 32768
// is pi and an angle of pi reads as -32768; a zero sample gives 0 and 0. The last
// flag travels with the word. A new word is taken every cycle unless the pipeline
// is full and the output is stalled. Each result passes these register stages in
// order: one for the half plane fold, one per CORDIC micro-rotation, one for the
// gain multiply and one for rounding. Every stage holds its word under
// back-pressure and empty stages still fill, so input is refused only when the
// whole pipeline is full and the output is stalled.
module complex_magnitude_phase #(
  parameter int SAMPLE_WIDTH = cmp_pkg::SAMPLE_WIDTH_DEF,
  parameter int ITERATIONS   = cmp_pkg::ITERATIONS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]     real_part_i,
  input  logic signed [SAMPLE_WIDTH-1:0]     imag_part_i,
  input  logic                               last_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [cmp_pkg::MAG_W-1:0]          magnitude_o,
  output logic signed [cmp_pkg::PHASE_W-1:0] phase_angle_o,
  output logic                               last_out_o
);

  localparam int DataWidth = SAMPLE_WIDTH + cmp_pkg::GUARD + cmp_pkg::HEADROOM;

  // Stage k of the rotation chain reads slot k and writes slot k+1.
  logic                        stg_valid [ITERATIONS+1];
  logic                        stg_ready [ITERATIONS+1];
  logic signed [DataWidth-1:0] stg_x     [ITERATIONS+1];
  logic signed [DataWidth-1:0] stg_y     [ITERATIONS+1];
  logic [cmp_pkg::ANGLE_W-1:0] stg_z     [ITERATIONS+1];
  cmp_pkg::cmp_tag_t           stg_tag   [ITERATIONS+1];

  // Half plane fold and guard bits.
  cmp_prerot #(
    .SampleWidth (SAMPLE_WIDTH),
    .DataWidth   (DataWidth)
  ) u_prerot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .real_i  (real_part_i),
    .imag_i  (imag_part_i),
    .last_i  (last_i),
    .valid_o (stg_valid[0]),
    .ready_i (stg_ready[0]),
    .x_o     (stg_x[0]),
    .y_o     (stg_y[0]),
    .z_o     (stg_z[0]),
    .tag_o   (stg_tag[0])
  );

  // One register stage per micro-rotation.
  for (genvar k = 0; k < ITERATIONS; k++) begin : g_rot
    cmp_cordic_stage #(
      .DataWidth (DataWidth),
      .Stage     (k)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[k]),
      .ready_o (stg_ready[k]),
      .x_i     (stg_x[k]),
      .y_i     (stg_y[k]),
      .z_i     (stg_z[k]),
      .tag_i   (stg_tag[k]),
      .valid_o (stg_valid[k+1]),
      .ready_i (stg_ready[k+1]),
      .x_o     (stg_x[k+1]),
      .y_o     (stg_y[k+1]),
      .z_o     (stg_z[k+1]),
      .tag_o   (stg_tag[k+1])
    );
  end

  // Gain correction and output register.
  cmp_gain #(
    .DataWidth (DataWidth)
  ) u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stg_valid[ITERATIONS]),
    .ready_o (stg_ready[ITERATIONS]),
    .x_i     (stg_x[ITERATIONS]),
    .z_i     (stg_z[ITERATIONS]),
    .tag_i   (stg_tag[ITERATIONS]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .mag_o   (magnitude_o),
    .phase_o (phase_angle_o),
    .last_o  (last_out_o)
  );

  // Input is refused only when the output holds a word that is not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while the output is free");

  // The real part never turns negative through the rotations.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_valid[ITERATIONS] |-> !stg_x[ITERATIONS][DataWidth-1])
    else $error("real part overflowed in the rotation chain");

  // A zero sample stays at the origin through every rotation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_valid[ITERATIONS] && stg_tag[ITERATIONS].zero) |->
      (stg_x[ITERATIONS] == '0 && stg_y[ITERATIONS] == '0))
    else $error("zero sample left the origin");

endmodule

// File: rtl/cmp_prerot.sv
// Input stage: sign extension, left half plane fold and guard bit shift.
module cmp_prerot #(
  parameter int SampleWidth = cmp_pkg::SAMPLE_WIDTH_DEF,
  parameter int DataWidth   = SampleWidth + cmp_pkg::GUARD + cmp_pkg::HEADROOM
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [SampleWidth-1:0] real_i,
  input  logic signed [SampleWidth-1:0] imag_i,
  input  logic                          last_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic signed [DataWidth-1:0]   x_o,
  output logic signed [DataWidth-1:0]   y_o,
  output logic [cmp_pkg::ANGLE_W-1:0]   z_o,
  output cmp_pkg::cmp_tag_t             tag_o
);

  logic signed [DataWidth-1:0] re_ext, im_ext, x_fold, y_fold;
  logic signed [DataWidth-1:0] x_d, y_d, x_q, y_q;
  logic [cmp_pkg::ANGLE_W-1:0] z_d, z_q;
  cmp_pkg::cmp_tag_t           tag_d, tag_q;
  logic                        valid_q;
  logic                        neg;

  // Fold the left half plane onto the right one and preset the angle to pi when folded.
  always_comb begin
    re_ext     = DataWidth'(real_i);
    im_ext     = DataWidth'(imag_i);
    neg        = re_ext[DataWidth-1];
    x_fold     = neg ? -re_ext : re_ext;
    y_fold     = neg ? -im_ext : im_ext;
    x_d        = x_fold <<< cmp_pkg::GUARD;
    y_d        = y_fold <<< cmp_pkg::GUARD;
    z_d        = neg ? cmp_pkg::ANGLE_PI : '0;
    tag_d.last = last_i;
    tag_d.zero = (real_i == '0) && (imag_i == '0);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
      tag_q <= tag_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign tag_o   = tag_q;

endmodule

// File: rtl/cmp_cordic_stage.sv
// One registered CORDIC vectoring micro-rotation.
module cmp_cordic_stage #(
  parameter int DataWidth = cmp_pkg::SAMPLE_WIDTH_DEF + cmp_pkg::GUARD + cmp_pkg::HEADROOM,
  parameter int Stage     = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic signed [DataWidth-1:0] x_i,
  input  logic signed [DataWidth-1:0] y_i,
  input  logic [cmp_pkg::ANGLE_W-1:0] z_i,
  input  cmp_pkg::cmp_tag_t           tag_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic signed [DataWidth-1:0] x_o,
  output logic signed [DataWidth-1:0] y_o,
  output logic [cmp_pkg::ANGLE_W-1:0] z_o,
  output cmp_pkg::cmp_tag_t           tag_o
);

  localparam logic [cmp_pkg::ANGLE_W-1:0] Atan = cmp_pkg::ATAN_TABLE[Stage];

  logic signed [DataWidth-1:0] xs, ys, x_d, y_d, x_q, y_q;
  logic [cmp_pkg::ANGLE_W-1:0] z_d, z_q;
  cmp_pkg::cmp_tag_t           tag_q;
  logic                        valid_q;

  // Rotate toward the real axis; the sign of y picks the direction.
  always_comb begin
    xs = x_i >>> Stage;
    ys = y_i >>> Stage;
    if (!y_i[DataWidth-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + Atan;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - Atan;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
      tag_q <= tag_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign tag_o   = tag_q;

endmodule

// File: rtl/cmp_gain.sv
// Gain correction multiply, then rounding, saturation and phase rounding.
module cmp_gain #(
  parameter int DataWidth = cmp_pkg::SAMPLE_WIDTH_DEF + cmp_pkg::GUARD + cmp_pkg::HEADROOM
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic signed [DataWidth-1:0]        x_i,
  input  logic [cmp_pkg::ANGLE_W-1:0]        z_i,
  input  cmp_pkg::cmp_tag_t                  tag_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic [cmp_pkg::MAG_W-1:0]          mag_o,
  output logic signed [cmp_pkg::PHASE_W-1:0] phase_o,
  output logic                               last_o
);

  localparam int ProdW  = DataWidth - 1 + cmp_pkg::GAIN_W;
  localparam int SumW   = ProdW + 1;
  localparam int RndPos = cmp_pkg::GAIN_W - 1 + cmp_pkg::GUARD;
  localparam int Shift  = cmp_pkg::GAIN_W + cmp_pkg::GUARD;

  logic [DataWidth-2:0]        x_pos;
  logic [ProdW-1:0]            prod_d, prod_q;
  logic [cmp_pkg::ANGLE_W-1:0] za_q, z_rnd;
  cmp_pkg::cmp_tag_t           taga_q;
  logic                        va_q, vb_q, ready_a, ready_b;
  logic [SumW-1:0]             sum, mag_full;
  logic [cmp_pkg::MAG_W-1:0]   mag_d, mag_q;
  logic [cmp_pkg::PHASE_W-1:0] phase_d, phase_q;
  logic                        lastb_q;

  // Multiply stage: clamp at zero and apply the CORDIC gain correction.
  always_comb begin
    x_pos  = x_i[DataWidth-1] ? '0 : x_i[DataWidth-2:0];
    prod_d = ProdW'(x_pos) * ProdW'(cmp_pkg::GAIN_Q24);
  end

  assign ready_a = !va_q || ready_b;
  assign ready_o = ready_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (ready_a) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && valid_i) begin
      prod_q <= prod_d;
      za_q   <= z_i;
      taga_q <= tag_i;
    end
  end

  // Output stage: round half up, saturate, and round the angle to 16 bits.
  always_comb begin
    sum      = {1'b0, prod_q} + (SumW'(1) << RndPos);
    mag_full = sum >> Shift;
    z_rnd    = za_q + cmp_pkg::ANGLE_HALF;
    if (mag_full > SumW'(cmp_pkg::MAG_MAX)) begin
      mag_d = cmp_pkg::MAG_MAX;
    end else begin
      mag_d = mag_full[cmp_pkg::MAG_W-1:0];
    end
    phase_d = z_rnd[cmp_pkg::ANGLE_W-1 -: cmp_pkg::PHASE_W];
    // A zero sample has no defined angle and reports zero.
    if (taga_q.zero) begin
      mag_d   = '0;
      phase_d = '0;
    end
  end

  assign ready_b = !vb_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (ready_b) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_b && va_q) begin
      mag_q   <= mag_d;
      phase_q <= phase_d;
      lastb_q <= taga_q.last;
    end
  end

  assign valid_o = vb_q;
  assign mag_o   = mag_q;
  assign phase_o = phase_q;
  assign last_o  = lastb_q;

endmodule
